// ----- design/pomscan_pkg.sv -----
// ----------------------------------------------------------------------------
// Page object marker scanner package
// Shared types, character codes and helper functions for the scanner.
// ----------------------------------------------------------------------------
package pomscan_pkg;

   // Character codes used by the marker detectors.
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_UPPER_T = 8'h54;
   localparam logic [7:0] CHAR_LOWER_Y = 8'h79;
   localparam logic [7:0] CHAR_LOWER_P = 8'h70;
   localparam logic [7:0] CHAR_LOWER_E = 8'h65;
   localparam logic [7:0] CHAR_UPPER_P = 8'h50;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_G = 8'h67;
   localparam logic [7:0] CHAR_LOWER_S = 8'h73;
   localparam logic [7:0] CHAR_UPPER_S = 8'h53;
   localparam logic [7:0] CHAR_LF      = 8'h0A;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_VT      = 8'h0B;
   localparam logic [7:0] CHAR_FF      = 8'h0C;
   localparam logic [7:0] CHAR_CR      = 8'h0D;

   // Progress of the "/Type" detector: bytes matched so far.
   localparam logic [2:0] TYPE_DONE_PROG = 3'd4;

   // Result queue geometry.
   localparam int QUEUE_DEPTH     = 8;
   localparam int QUEUE_PTR_BITS  = 3;
   localparam int QUEUE_CNT_BITS  = 4;

   // Phase of a pending candidate after "/Type" has been seen.
   typedef enum logic [2:0] {
      PH_IDLE,
      PH_BLANK,
      PH_SLASH,
      PH_P,
      PH_PA,
      PH_PAG,
      PH_PAGE
   } phase_type;

   // Queue push request produced by the scanner core for one byte.
   typedef struct packed {
      logic match_push;
      logic end_push;
      logic any_found;
   } push_ctrl_type;

   // Expected byte of "/Type" for a given amount of progress.
   function automatic logic [7:0] type_char(input logic [2:0] prog);
      logic [7:0] ch;
      case (prog)
         3'd0:    ch = CHAR_SLASH;
         3'd1:    ch = CHAR_UPPER_T;
         3'd2:    ch = CHAR_LOWER_Y;
         3'd3:    ch = CHAR_LOWER_P;
         3'd4:    ch = CHAR_LOWER_E;
         default: ch = CHAR_SLASH;
      endcase
      return ch;
   endfunction

   // Whitespace test: space, tab, LF, VT, FF and CR.
   function automatic logic is_blank(input logic [7:0] b);
      return b inside {CHAR_SPACE, CHAR_TAB, CHAR_LF, CHAR_VT, CHAR_FF, CHAR_CR};
   endfunction

endpackage

// ----- design/pomscan_core.sv -----
// ----------------------------------------------------------------------------
// Page object marker scanner core
// Holds the scan state and processes one registered byte per cycle.
// ----------------------------------------------------------------------------
module pomscan_core #(
   parameter int OFFSET_BITS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic [7:0]                  in_byte,
   input  logic                        in_final,
   output pomscan_pkg::push_ctrl_type  push,
   output logic [OFFSET_BITS-1:0]      match_offset
);
   import pomscan_pkg::*;

   localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

   phase_type               phase_ff, phase_in;
   logic [2:0]              tprog_ff, tprog_in;
   logic [2:0]              tprog_cur;
   logic [OFFSET_BITS-1:0]  pos_ff, pos_in;
   logic [OFFSET_BITS-1:0]  lnl_ff, lnl_in;
   logic [OFFSET_BITS-1:0]  cls_ff, cls_in;
   logic                    seen_ff, seen_in;

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         tprog_ff <= '0;
         pos_ff   <= '0;
         lnl_ff   <= '0;
         cls_ff   <= '0;
         seen_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         tprog_ff <= tprog_in;
         pos_ff   <= pos_in;
         lnl_ff   <= lnl_in;
         cls_ff   <= cls_in;
         seen_ff  <= seen_in;
      end
   end

   // A match reports the latest LF position captured when its "/Type" completed.
   assign match_offset = cls_ff;

   assign tprog_cur = (tprog_ff > TYPE_DONE_PROG) ? 3'd0 : tprog_ff;

   // Next state and queue pushes for the byte in the input register.
   always_comb begin
      phase_in = phase_ff;
      tprog_in = tprog_ff;
      pos_in   = pos_ff;
      lnl_in   = lnl_ff;
      cls_in   = cls_ff;
      seen_in  = seen_ff;
      push     = '0;
      if (in_valid) begin
         // Advance the pending candidate.
         case (phase_ff)
            PH_PAGE: begin
               if (in_byte != CHAR_LOWER_S && in_byte != CHAR_UPPER_S) begin
                  push.match_push = 1'b1;
               end
               phase_in = PH_IDLE;
            end
            PH_BLANK: begin
               if (is_blank(in_byte)) begin
                  phase_in = PH_BLANK;
               end else if (in_byte == CHAR_SLASH) begin
                  phase_in = PH_SLASH;
               end else begin
                  phase_in = PH_IDLE;
               end
            end
            PH_SLASH: phase_in = (in_byte == CHAR_UPPER_P) ? PH_P : PH_IDLE;
            PH_P:     phase_in = (in_byte == CHAR_LOWER_A) ? PH_PA : PH_IDLE;
            PH_PA:    phase_in = (in_byte == CHAR_LOWER_G) ? PH_PAG : PH_IDLE;
            PH_PAG:   phase_in = (in_byte == CHAR_LOWER_E) ? PH_PAGE : PH_IDLE;
            default:  phase_in = PH_IDLE;
         endcase

         // A "/Page" ending on the last byte is decided by an implied NUL.
         if (phase_in == PH_PAGE && in_final) begin
            push.match_push = 1'b1;
            phase_in        = PH_IDLE;
         end
         if (push.match_push) begin
            seen_in = 1'b1;
         end

         // The "/Type" detector runs on every byte.
         if (tprog_cur == TYPE_DONE_PROG && in_byte == CHAR_LOWER_E) begin
            if (!in_final) begin
               phase_in = PH_BLANK;
               cls_in   = lnl_ff;
            end
            tprog_in = 3'd0;
         end else if (in_byte == type_char(tprog_cur)) begin
            tprog_in = tprog_cur + 3'd1;
         end else begin
            tprog_in = (in_byte == CHAR_SLASH) ? 3'd1 : 3'd0;
         end

         // Track the latest LF and the saturating byte position.
         if (in_byte == CHAR_LF) begin
            lnl_in = pos_ff;
         end
         if (pos_ff != POS_MAX) begin
            pos_in = pos_ff + 1'b1;
         end

         // The last byte closes the buffer and clears the scan state.
         if (in_final) begin
            push.end_push  = 1'b1;
            push.any_found = seen_in;
            phase_in       = PH_IDLE;
            tprog_in       = '0;
            pos_in         = '0;
            lnl_in         = '0;
            cls_in         = '0;
            seen_in        = 1'b0;
         end
      end
   end

endmodule

// ----- design/pomscan_rsp_queue.sv -----
// ----------------------------------------------------------------------------
// Page object marker scanner result queue
// Small queue that takes up to two results per cycle and feeds the output.
// ----------------------------------------------------------------------------
module pomscan_rsp_queue #(
   parameter int OFFSET_BITS = 32
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  pomscan_pkg::push_ctrl_type              push,
   input  logic [OFFSET_BITS-1:0]                  match_offset,
   output logic [pomscan_pkg::QUEUE_CNT_BITS-1:0]  level,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [OFFSET_BITS-1:0]                  rsp_object_offset,
   output logic                                    rsp_end_report,
   output logic                                    rsp_any_found
);
   import pomscan_pkg::*;

   logic [OFFSET_BITS-1:0]     offset_ff [QUEUE_DEPTH];
   logic                       end_ff    [QUEUE_DEPTH];
   logic                       found_ff  [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]  head_ff, head_in;
   logic [QUEUE_PTR_BITS-1:0]  tail_ff, tail_in;
   logic [QUEUE_PTR_BITS-1:0]  end_slot;
   logic [QUEUE_CNT_BITS-1:0]  count_ff, count_in;
   logic [1:0]                 push_cnt;
   logic                       pop;

   assign pop      = rsp_valid && !rsp_stall;
   assign push_cnt = {1'b0, push.match_push} + {1'b0, push.end_push};
   assign end_slot = tail_ff + {{(QUEUE_PTR_BITS-1){1'b0}}, push.match_push};

   // Pointer and fill count updates.
   always_comb begin
      head_in  = head_ff + {{(QUEUE_PTR_BITS-1){1'b0}}, pop};
      tail_in  = tail_ff + {{(QUEUE_PTR_BITS-2){1'b0}}, push_cnt};
      count_in = count_ff + {{(QUEUE_CNT_BITS-2){1'b0}}, push_cnt}
                 - {{(QUEUE_CNT_BITS-1){1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Entry storage: a match result goes first, the end result after it.
   always_ff @(posedge clock) begin
      if (push.match_push) begin
         offset_ff[tail_ff] <= match_offset;
         end_ff[tail_ff]    <= 1'b0;
         found_ff[tail_ff]  <= 1'b0;
      end
      if (push.end_push) begin
         offset_ff[end_slot] <= '0;
         end_ff[end_slot]    <= 1'b1;
         found_ff[end_slot]  <= push.any_found;
      end
   end

   // The head entry drives the result channel.
   assign level             = count_ff;
   assign rsp_valid         = (count_ff != '0);
   assign rsp_object_offset = offset_ff[head_ff];
   assign rsp_end_report    = end_ff[head_ff];
   assign rsp_any_found     = found_ff[head_ff];

endmodule

// ----- design/page_object_marker_scanner_top.sv -----
// ----------------------------------------------------------------------------
// Page object marker scanner top level
// Scans a byte stream for "/Type" then "/Page" and reports line offsets.
// ----------------------------------------------------------------------------
// Path: an accepted byte is held in the input register, the core then writes its
// results into the result queue, and the head entry of the queue is offered.
// Throughput: one byte per cycle; the input stalls once the result queue holds
// more than four entries, or more than two while a byte waits in the input
// register, which happens only while the result side holds back.
// Reset: synchronous, clears the scan state, the input stage and the queue.
module page_object_marker_scanner_top #(
   parameter int OFFSET_BITS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [7:0]              req_data_byte,
   input  logic                    req_final_byte,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [OFFSET_BITS-1:0]  rsp_object_offset,
   output logic                    rsp_end_report,
   output logic                    rsp_any_found
);
   import pomscan_pkg::*;

   localparam logic [QUEUE_CNT_BITS:0] ACCEPT_LIMIT = (QUEUE_CNT_BITS+1)'(QUEUE_DEPTH - 4);

   logic                        s1_valid_ff, s1_valid_in;
   logic [7:0]                  s1_byte_ff;
   logic                        s1_final_ff;
   logic                        accept;
   logic [QUEUE_CNT_BITS-1:0]   level;
   logic [QUEUE_CNT_BITS:0]     committed;
   push_ctrl_type               push;
   logic [OFFSET_BITS-1:0]      match_offset;

   // Room check: each transaction in flight may add two results.
   assign committed = {1'b0, level} + (s1_valid_ff ? (QUEUE_CNT_BITS+1)'(2) : '0);
   assign req_stall = (committed > ACCEPT_LIMIT);
   assign accept    = req_valid && !req_stall;
   assign s1_valid_in = accept;

   // Input register stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_byte_ff  <= req_data_byte;
         s1_final_ff <= req_final_byte;
      end
   end

   pomscan_core #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (s1_valid_ff),
      .in_byte      (s1_byte_ff),
      .in_final     (s1_final_ff),
      .push         (push),
      .match_offset (match_offset)
   );

   pomscan_rsp_queue #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_rsp_queue (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .match_offset      (match_offset),
      .level             (level),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_object_offset (rsp_object_offset),
      .rsp_end_report    (rsp_end_report),
      .rsp_any_found     (rsp_any_found)
   );

endmodule
